// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lits_pkg.sv =====
// ----------------------------------------------------------------------------
// lits_pkg
// Shared types and constants of the linear interpolation resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lits_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MAX_RUN_DEF    = 64;

    localparam int SAMPLE_W   = 16;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;
    localparam int STEP_W     = 32;
    localparam int TOTAL_W    = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POSITION_STEP = 1'b0,
        REG_OUTPUT_TOTAL  = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_MUL,
        S_SUM,
        S_EMIT,
        S_JUDGE,
        S_SEND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
        logic emit;
        logic judge;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic more;
        logic last;
    } t_status;

endpackage

`default_nettype wire

// ===== sv/lits_ctrl.sv =====
// ----------------------------------------------------------------------------
// lits_ctrl
// Sequencer: accepts a source sample, steps the datapath once per result and
// hands each result over the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lits_ctrl
    import lits_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  wire     i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FIRST;
                end
            end
            S_FIRST: begin
                n_state = i_status.more ? S_MUL : S_DONE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_JUDGE;
            end
            S_JUDGE: begin
                o_cmd.judge = 1'b1;
                n_state     = S_SEND;
            end
            S_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = i_status.last ? S_DONE : S_MUL;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
        endcase
    end

    `CHK_IMPL(a_done_no_work, r_state == S_DONE, !i_status.more, "item closed with work left")
    `CHK_NEXT(a_send_holds, (r_state == S_SEND) && !i_out_ready, r_state == S_SEND,
              "result dropped while stalled")

endmodule

`default_nettype wire

// ===== sv/lits_dpath.sv =====
// ----------------------------------------------------------------------------
// lits_dpath
// Position tracking, interpolation multiply, rounding and clamping, plus the
// configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lits_dpath
    import lits_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int MAX_RUN    = MAX_RUN_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire [SAMPLE_W-1:0]    i_in_sample,
    input  wire                   i_in_final,
    output logic [SAMPLE_W-1:0]   o_res_sample,
    output logic                  o_res_last,
    output logic                  o_res_wave,
    input  t_cmd                  i_cmd,
    output t_status               o_status
);

    localparam int POS_W  = COUNT_BITS + FRAC_BITS;
    localparam int SUM_W  = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;
    localparam int RUN_W  = $clog2(MAX_RUN + 1);
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam int T_W    = SAMPLE_W + FRAC_BITS + 3;
    localparam int Q_W    = T_W - FRAC_BITS;
    localparam logic [T_W-1:0] HALF = T_W'(1) << (FRAC_BITS - 1);

    logic [STEP_W-1:0]            r_step;
    logic [COUNT_BITS-1:0]        r_total;
    logic signed [SAMPLE_W-1:0]   r_prev;
    logic                         r_have_prev;
    logic [COUNT_BITS-1:0]        r_src_idx;
    logic [POS_W-1:0]             r_pos;
    logic [COUNT_BITS-1:0]        r_emitted;
    logic [RUN_W-1:0]             r_run_cnt;

    logic signed [SAMPLE_W-1:0]   r_cur;
    logic                         r_fin;
    logic signed [SAMPLE_W-1:0]   r_a;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [T_W-1:0]        r_t;
    logic [SAMPLE_W-1:0]          r_res;
    logic                         r_wave;
    logic                         r_last;

    logic [COUNT_BITS-1:0]        pos_int;
    logic [FRAC_BITS-1:0]         pos_frac;
    logic [COUNT_BITS-1:0]        idx_m1;
    logic                         room;
    logic                         more_interp;
    logic                         more_hold;
    logic [FRAC_BITS-1:0]         frac_sel;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [DIFF_W-1:0]     mul_diff;
    logic signed [FRAC_BITS:0]    mul_frac;
    logic signed [PROD_W-1:0]     mul_prod;
    logic signed [T_W-1:0]        n_t;
    logic signed [T_W-1:0]        rnd;
    logic signed [Q_W-1:0]        q;
    logic [SAMPLE_W-1:0]          n_res;
    logic [SUM_W-1:0]             pos_sum;
    logic [POS_W-1:0]             n_pos;
    logic [COUNT_BITS-1:0]        emitted_inc;

    assign pos_int  = r_pos[POS_W-1:FRAC_BITS];
    assign pos_frac = r_pos[FRAC_BITS-1:0];
    assign idx_m1   = r_src_idx - COUNT_BITS'(1);

    assign room        = (r_run_cnt < RUN_W'(MAX_RUN)) && (r_emitted < r_total);
    assign more_interp = r_have_prev && room && (pos_int < r_src_idx);
    assign more_hold   = r_fin && room;

    // positions lagging the current pair take a zero fraction
    assign frac_sel = (pos_int >= idx_m1) ? pos_frac : '0;
    assign diff     = DIFF_W'(r_cur) - DIFF_W'(r_prev);
    assign mul_diff = more_interp ? diff : '0;
    assign mul_frac = more_interp ? {1'b0, frac_sel} : '0;
    assign mul_prod = PROD_W'(mul_diff) * PROD_W'(mul_frac);

    assign n_t = (T_W'(r_a) <<< FRAC_BITS) + T_W'(r_prod);

    // half away from zero: negative values take half minus one before the floor
    assign rnd = r_t + $signed(r_t[T_W-1] ? (HALF - T_W'(1)) : HALF);
    assign q   = rnd[T_W-1:FRAC_BITS];

    always_comb begin
        priority if (q > Q_W'(SAMPLE_MAX)) begin
            n_res = SAMPLE_W'(SAMPLE_MAX);
        end else if (q < Q_W'(SAMPLE_MIN)) begin
            n_res = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            n_res = q[SAMPLE_W-1:0];
        end
    end

    assign pos_sum     = SUM_W'(r_pos) + SUM_W'(r_step);
    assign n_pos       = (|pos_sum[SUM_W-1:POS_W]) ? '1 : pos_sum[POS_W-1:0];
    assign emitted_inc = r_emitted + COUNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RESET;
            r_total     <= '0;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_src_idx   <= '0;
            r_pos       <= '0;
            r_emitted   <= '0;
            r_run_cnt   <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_POSITION_STEP: r_step  <= i_cfg_data[STEP_W-1:0];
                    REG_OUTPUT_TOTAL:  r_total <= COUNT_BITS'(i_cfg_data[TOTAL_W-1:0]);
                endcase
            end
            if (i_cmd.load) begin
                r_run_cnt <= '0;
            end
            if (i_cmd.emit) begin
                r_pos     <= n_pos;
                r_emitted <= emitted_inc;
                r_run_cnt <= r_run_cnt + RUN_W'(1);
            end
            if (i_cmd.finish) begin
                if (r_fin) begin
                    r_prev      <= '0;
                    r_have_prev <= 1'b0;
                    r_src_idx   <= '0;
                    r_pos       <= '0;
                    r_emitted   <= '0;
                end else begin
                    r_prev      <= r_cur;
                    r_have_prev <= 1'b1;
                    r_src_idx   <= r_src_idx + COUNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur <= $signed(i_in_sample);
            r_fin <= i_in_final;
        end
        if (i_cmd.mul) begin
            r_a    <= more_interp ? r_prev : r_cur;
            r_prod <= mul_prod;
        end
        if (i_cmd.sum) begin
            r_t <= n_t;
        end
        if (i_cmd.emit) begin
            r_res  <= n_res;
            r_wave <= (emitted_inc == r_total);
        end
        if (i_cmd.judge) begin
            r_last <= !(more_interp || more_hold);
        end
    end

    assign o_status.more = more_interp || more_hold;
    assign o_status.last = r_last;
    assign o_res_sample  = r_res;
    assign o_res_last    = r_last;
    assign o_res_wave    = r_fin ? r_last : r_wave;

    `CHK_IMPL(a_run_bound, 1'b1, r_run_cnt <= RUN_W'(MAX_RUN), "run count past cap")
    `CHK_NEXT(a_final_clears, i_cmd.finish && r_fin,
              !r_have_prev && (r_pos == '0) && (r_emitted == '0), "waveform end left state")
    `CHK_NEXT(a_pos_monotone, !i_cmd.finish, r_pos >= $past(r_pos), "position stepped back")

endmodule

`default_nettype wire

// ===== sv/linear_interp_time_stretch.sv =====
// Linear interpolation resampler. Signed 16-bit source samples enter on the
// slave stream, tlast on the last sample of a waveform; output number i sits
// at source position i * position_step (unsigned Q16.16) and is formed from
// the bracketing pair, rounded half away from zero. On the final sample the
// outputs still owed up to output_total repeat it, then the block clears its
// position and sample state but keeps its configuration. One item is handled
// at a time through a single multiply and round path: an item that yields no
// result passes through load, first check and done, and each result passes
// through multiply, sum, round, run check and transfer plus any wait on
// m_axis_tready, at most MAX_RUN results per item. Configuration writes are
// always accepted and must be issued only while no item is in flight.
// ----------------------------------------------------------------------------
// linear_interp_time_stretch
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_interp_time_stretch
    import lits_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int MAX_RUN    = MAX_RUN_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire [SAMPLE_W-1:0]    i_s_axis_tdata,   // [15:0] sample_in
    input  wire                   i_s_axis_tlast,   // final_sample
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    output logic [SAMPLE_W-1:0]   o_m_axis_tdata,   // [15:0] sample_out
    output logic                  o_m_axis_tlast,   // run_last
    output logic                  o_m_axis_tuser    // [0] wave_done
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    lits_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    lits_dpath #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .MAX_RUN    (MAX_RUN)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_sample  (i_s_axis_tdata),
        .i_in_final   (i_s_axis_tlast),
        .o_res_sample (o_m_axis_tdata),
        .o_res_last   (o_m_axis_tlast),
        .o_res_wave   (o_m_axis_tuser),
        .i_cmd        (cmd),
        .o_status     (status)
    );

endmodule

`default_nettype wire
